### rtl/tcd_pkg.sv
// Shared types, codes and color widening functions for the texel format / palette decoder.
`timescale 1ns / 1ps
`default_nettype none
package tcd_pkg;

    localparam int PALETTE_HALFWORDS_DEFAULT = 1024;
    localparam int QUEUE_DEPTH = 2;

    // Texel format codes
    localparam logic [2:0] TEX_565   = 3'd0;
    localparam logic [2:0] TEX_5551  = 3'd1;
    localparam logic [2:0] TEX_4444  = 3'd2;
    localparam logic [2:0] TEX_8888  = 3'd3;
    localparam logic [2:0] TEX_PAL4  = 3'd4;
    localparam logic [2:0] TEX_PAL8  = 3'd5;
    localparam logic [2:0] TEX_PAL16 = 3'd6;
    localparam logic [2:0] TEX_PAL32 = 3'd7;

    // Palette entry format codes
    localparam logic [1:0] PAL_565  = 2'd0;
    localparam logic [1:0] PAL_5551 = 2'd1;
    localparam logic [1:0] PAL_4444 = 2'd2;
    localparam logic [1:0] PAL_8888 = 2'd3;

    // Input opcodes
    localparam logic OPCODE_DECODE = 1'b0;
    localparam logic OPCODE_WRITE  = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_TEXEL_FORMAT   = 3'd0;
    localparam logic [2:0] REG_PALETTE_FORMAT = 3'd1;
    localparam logic [2:0] REG_INDEX_SHIFT    = 3'd2;
    localparam logic [2:0] REG_INDEX_MASK     = 3'd3;
    localparam logic [2:0] REG_INDEX_OFFSET   = 3'd4;
    localparam logic [2:0] REG_SHARED_PALETTE = 3'd5;

    typedef struct packed {
        logic [2:0] texel_format;
        logic [1:0] palette_format;
        logic [4:0] index_shift;
        logic [7:0] index_mask;
        logic [4:0] index_offset;
        logic       shared_palette;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_WRITE,
        KIND_DIRECT,
        KIND_PALETTE
    } kind_t;

    // One queued word: direct color or write data in payload, halfword address in addr.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] payload;
        logic [9:0]  addr;
    } entry_t;

    function automatic logic [31:0] widen_565(input logic [15:0] v);
        widen_565 = {8'hFF, v[15:11], v[15:13], v[10:5], v[10:9], v[4:0], v[4:2]};
    endfunction

    function automatic logic [31:0] widen_5551(input logic [15:0] v);
        widen_5551 = {{8{v[15]}}, v[14:10], v[14:12], v[9:5], v[9:7], v[4:0], v[4:2]};
    endfunction

    function automatic logic [31:0] widen_4444(input logic [15:0] v);
        widen_4444 = {v[15:12], v[15:12], v[11:8], v[11:8], v[7:4], v[7:4], v[3:0], v[3:0]};
    endfunction

    function automatic logic [31:0] decode_format(input logic [1:0] fmt, input logic [31:0] v);
        logic [31:0] res;
        case (fmt)
            PAL_565:  res = widen_565(v[15:0]);
            PAL_5551: res = widen_5551(v[15:0]);
            PAL_4444: res = widen_4444(v[15:0]);
            default:  res = v;
        endcase
        decode_format = res;
    endfunction

endpackage
`default_nettype wire

### rtl/tcd_front.sv
// Front end: classifies each accepted word and forms its color or palette address.
`timescale 1ns / 1ps
`default_nettype none
module tcd_front #(
    parameter int PALETTE_HALFWORDS = tcd_pkg::PALETTE_HALFWORDS_DEFAULT
) (
    input  wire tcd_pkg::cfg_t cfg,
    input  wire logic       opcode,
    input  wire logic [31:0] texel_value,
    input  wire logic [2:0] mip_level,
    input  wire logic       source_valid,
    input  wire logic [9:0] palette_addr,
    input  wire logic [15:0] palette_data,
    output tcd_pkg::entry_t entry
);
    import tcd_pkg::*;

    localparam int AW = $clog2(PALETTE_HALFWORDS);
    localparam int CW = AW + 1;

    logic [31:0] raw;
    logic [31:0] shifted;
    logic [7:0]  idx8;
    logic [8:0]  idx9;
    logic [9:0]  idx10;
    logic        wr_in_range;

    always_comb begin
        case (cfg.texel_format)
            TEX_PAL4:  raw = {28'd0, texel_value[3:0]};
            TEX_PAL8:  raw = {24'd0, texel_value[7:0]};
            TEX_PAL16: raw = {16'd0, texel_value[15:0]};
            default:   raw = texel_value;
        endcase
        shifted = raw >> cfg.index_shift;
        idx8    = shifted[7:0] & cfg.index_mask;
        idx9    = {cfg.index_offset, 4'd0} | {1'b0, idx8};
        if (cfg.palette_format == PAL_8888) begin
            idx9[8] = 1'b0;
        end
        idx10 = {1'b0, idx9};
        if (!cfg.shared_palette) begin
            idx10 = idx10 + {3'd0, mip_level, 4'd0};
        end
    end

    assign wr_in_range = CW'(palette_addr) < CW'(PALETTE_HALFWORDS);

    always_comb begin
        entry.kind    = KIND_DIRECT;
        entry.payload = 32'd0;
        entry.addr    = 10'd0;
        if (opcode == OPCODE_WRITE) begin
            // drop writes past the end of the RAM
            entry.kind    = wr_in_range ? KIND_WRITE : KIND_NOP;
            entry.payload = {16'd0, palette_data};
            entry.addr    = palette_addr;
        end else if (source_valid) begin
            case (cfg.texel_format)
                TEX_565:  entry.payload = widen_565(texel_value[15:0]);
                TEX_5551: entry.payload = widen_5551(texel_value[15:0]);
                TEX_4444: entry.payload = widen_4444(texel_value[15:0]);
                TEX_8888: entry.payload = texel_value;
                default: begin
                    entry.kind = KIND_PALETTE;
                    entry.addr = (cfg.palette_format == PAL_8888) ?
                                 {idx10[8:0], 1'b0} : idx10;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/tcd_queue.sv
// Short FIFO between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module tcd_queue (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire tcd_pkg::entry_t push_entry,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output tcd_pkg::entry_t head_entry
);
    import tcd_pkg::*;

    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    entry_t           q_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;

    assign full       = count_reg == QCW'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue pop while empty");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule
`default_nettype wire

### rtl/tcd_back.sv
// Back end: palette RAM access, entry decode and the output register.
`timescale 1ns / 1ps
`default_nettype none
module tcd_back #(
    parameter int PALETTE_HALFWORDS = tcd_pkg::PALETTE_HALFWORDS_DEFAULT
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [1:0] palette_format,
    input  wire logic       head_valid,
    input  wire tcd_pkg::entry_t head_entry,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [31:0]     m_color
);
    import tcd_pkg::*;

    localparam int AW = $clog2(PALETTE_HALFWORDS);
    localparam int CW = AW + 1;

    logic [15:0]   mem [PALETTE_HALFWORDS];

    logic [CW-1:0] ha_ext, hb_ext;
    logic [AW-1:0] rd_addr_lo, rd_addr_hi;
    logic          out_room;
    logic          mem_advance;
    logic          head_has_result;

    logic          mem_valid_reg, mem_valid_next;
    logic          mem_palette_reg;
    logic [31:0]   mem_color_reg;
    logic [15:0]   rd_lo_reg, rd_hi_reg;
    logic [31:0]   color_now;

    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_color_reg;

    // wrap halfword addresses modulo the RAM size; they stay below twice it
    always_comb begin
        ha_ext = CW'(head_entry.addr);
        hb_ext = CW'(head_entry.addr) + 1'b1;
        if (ha_ext >= CW'(PALETTE_HALFWORDS)) begin
            ha_ext = ha_ext - CW'(PALETTE_HALFWORDS);
        end
        if (hb_ext >= CW'(PALETTE_HALFWORDS)) begin
            hb_ext = hb_ext - CW'(PALETTE_HALFWORDS);
        end
    end

    assign rd_addr_lo = ha_ext[AW-1:0];
    assign rd_addr_hi = hb_ext[AW-1:0];

    assign out_room        = !m_valid_reg || m_ready;
    assign mem_advance     = mem_valid_reg && out_room;
    assign pop             = head_valid && (!mem_valid_reg || mem_advance);
    assign head_has_result = (head_entry.kind == KIND_DIRECT) ||
                             (head_entry.kind == KIND_PALETTE);

    always_comb begin
        mem_valid_next = mem_valid_reg;
        if (pop) begin
            mem_valid_next = head_has_result;
        end else if (mem_advance) begin
            mem_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (mem_advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            mem_valid_reg <= mem_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // palette RAM: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (pop && head_entry.kind == KIND_WRITE) begin
            mem[AW'(head_entry.addr)] <= head_entry.payload[15:0];
        end
        if (pop && head_entry.kind == KIND_PALETTE) begin
            rd_lo_reg <= mem[rd_addr_lo];
            rd_hi_reg <= mem[rd_addr_hi];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head_has_result) begin
            mem_palette_reg <= head_entry.kind == KIND_PALETTE;
            mem_color_reg   <= head_entry.payload;
        end
    end

    assign color_now = mem_palette_reg ?
                       decode_format(palette_format, {rd_hi_reg, rd_lo_reg}) : mem_color_reg;

    always_ff @(posedge aclk) begin
        if (mem_advance) begin
            m_color_reg <= color_now;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_color = m_color_reg;

    a_read_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_valid_reg && !mem_advance) |=>
            ((rd_lo_reg === $past(rd_lo_reg)) && (rd_hi_reg === $past(rd_hi_reg))))
        else $error("palette read data changed under a stalled word");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && (m_color === $past(m_color))))
        else $error("output word dropped or changed while stalled");

    a_pop_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!mem_valid_reg || out_room))
        else $error("queue popped into a blocked read stage");

endmodule
`default_nettype wire

### rtl/texel_format_clut_decoder_top.sv
// Top level: APB register file, front end, queue and back end of the texel decoder.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+--------------------------------------------
//  s_       | in        | s_valid/s_ready  | opcode, texel_value, mip_level,
//           |           |                  | source_valid, palette_addr, palette_data
//  m_       | out       | m_valid/m_ready  | color
//  apb      | in        | psel/penable     | paddr, pwdata, prdata, pready
//
//  One word per cycle sustained while m_ready stays high; a decode result passes the queue,
//  the registered palette RAM read and the output register before it is presented.
//  8888 palettes read both halfwords in the same cycle through the RAM's two read ports.
//  Palette writes produce no result and take one queue slot.
//  Reset is synchronous; the palette RAM is not cleared and reads undefined until written.
//  Stalls on m_ready back up through the output register and the two-word queue.
`timescale 1ns / 1ps
`default_nettype none
module texel_format_clut_decoder_top #(
    parameter int PALETTE_HALFWORDS = tcd_pkg::PALETTE_HALFWORDS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [31:0] s_texel_value,
    input  wire logic [2:0]  s_mip_level,
    input  wire logic        s_source_valid,
    input  wire logic [9:0]  s_palette_addr,
    input  wire logic [15:0] s_palette_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_color,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tcd_pkg::*;

    logic [2:0] texel_format_reg;
    logic [1:0] palette_format_reg;
    logic [4:0] index_shift_reg;
    logic [7:0] index_mask_reg;
    logic [4:0] index_offset_reg;
    logic       shared_palette_reg;

    logic [2:0] reg_index;
    logic       cfg_write;
    cfg_t       cfg;
    entry_t     front_entry;
    entry_t     head_entry;
    logic       q_full;
    logic       head_valid;
    logic       pop;
    logic       push;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            texel_format_reg   <= TEX_565;
            palette_format_reg <= PAL_565;
            index_shift_reg    <= 5'd0;
            index_mask_reg     <= 8'hFF;
            index_offset_reg   <= 5'd0;
            shared_palette_reg <= 1'b1;
        end else if (cfg_write) begin
            case (reg_index)
                REG_TEXEL_FORMAT:   texel_format_reg   <= pwdata[2:0];
                REG_PALETTE_FORMAT: palette_format_reg <= pwdata[1:0];
                REG_INDEX_SHIFT:    index_shift_reg    <= pwdata[4:0];
                REG_INDEX_MASK:     index_mask_reg     <= pwdata[7:0];
                REG_INDEX_OFFSET:   index_offset_reg   <= pwdata[4:0];
                REG_SHARED_PALETTE: shared_palette_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_TEXEL_FORMAT:   prdata = {29'd0, texel_format_reg};
            REG_PALETTE_FORMAT: prdata = {30'd0, palette_format_reg};
            REG_INDEX_SHIFT:    prdata = {27'd0, index_shift_reg};
            REG_INDEX_MASK:     prdata = {24'd0, index_mask_reg};
            REG_INDEX_OFFSET:   prdata = {27'd0, index_offset_reg};
            REG_SHARED_PALETTE: prdata = {31'd0, shared_palette_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.texel_format   = texel_format_reg;
        cfg.palette_format = palette_format_reg;
        cfg.index_shift    = index_shift_reg;
        cfg.index_mask     = index_mask_reg;
        cfg.index_offset   = index_offset_reg;
        cfg.shared_palette = shared_palette_reg;
    end

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    tcd_front #(
        .PALETTE_HALFWORDS(PALETTE_HALFWORDS)
    ) u_front (
        .cfg          (cfg),
        .opcode       (s_opcode),
        .texel_value  (s_texel_value),
        .mip_level    (s_mip_level),
        .source_valid (s_source_valid),
        .palette_addr (s_palette_addr),
        .palette_data (s_palette_data),
        .entry        (front_entry)
    );

    tcd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    tcd_back #(
        .PALETTE_HALFWORDS(PALETTE_HALFWORDS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .palette_format (palette_format_reg),
        .head_valid     (head_valid),
        .head_entry     (head_entry),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_color        (m_color)
    );

endmodule
`default_nettype wire

### bench/tb_texel_format_clut_decoder_top.sv
// Testbench for the texel format / palette decoder: directed table, random phases, color checking.
`timescale 1ns / 1ps
module tb_texel_format_clut_decoder_top;
    import tcd_pkg::*;

    localparam int PAL_WORDS = 1024;
    localparam int DIR_ROWS  = 22;
    localparam int PHASES    = 12;
    localparam int PHASE_WORDS = 125;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic        opcode;
        logic [31:0] texel;
        logic [2:0]  level;
        logic        src_ok;
        logic [9:0]  addr;
        logic [15:0] data;
    } texel_word_t;

    typedef struct {
        logic [2:0]  tfmt;
        logic [1:0]  pfmt;
        logic        opcode;
        logic [31:0] texel;
        logic [2:0]  level;
        logic        src_ok;
        logic [9:0]  addr;
        logic [15:0] data;
        bit          typed;
        logic [31:0] color;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = 1'b0;
    logic [31:0] s_texel_value = '0;
    logic [2:0]  s_mip_level = '0;
    logic        s_source_valid = 1'b0;
    logic [9:0]  s_palette_addr = '0;
    logic [15:0] s_palette_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_color;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the block's registers and palette
    cfg_t        cfg;
    logic [15:0] pal_mem [PAL_WORDS];
    bit          pal_written [PAL_WORDS];

    logic [31:0] color_expect [$];
    int          fail_count = 0;
    int          colors_seen = 0;
    int          words_in = 0;
    int          pal_writes = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_ask = 0;
    int          hold_taken = 0;
    int          hold_left = 0;

    dir_row_t    dir_rows [DIR_ROWS];

    texel_format_clut_decoder_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_texel_value  (s_texel_value),
        .s_mip_level    (s_mip_level),
        .s_source_valid (s_source_valid),
        .s_palette_addr (s_palette_addr),
        .s_palette_data (s_palette_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_color        (m_color),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] rep5(input logic [4:0] x);
        return {x, x[4:2]};
    endfunction

    function automatic logic [7:0] rep6(input logic [5:0] x);
        return {x, x[5:4]};
    endfunction

    function automatic logic [31:0] unpack_color(input logic [1:0] fmt, input logic [31:0] v);
        logic [31:0] c;
        case (fmt)
            PAL_565:  c = {8'hFF, rep5(v[15:11]), rep6(v[10:5]), rep5(v[4:0])};
            PAL_5551: c = {(v[15] ? 8'hFF : 8'h00), rep5(v[14:10]), rep5(v[9:5]), rep5(v[4:0])};
            PAL_4444: begin
                c = '0;
                for (int k = 0; k < 4; k++) begin
                    c[8*k +: 8] = {v[4*k +: 4], v[4*k +: 4]};
                end
            end
            default:  c = v;
        endcase
        return c;
    endfunction

    // index bits that the current texel format actually uses
    function automatic logic [31:0] texel_index_bits(input logic [31:0] texel);
        case (cfg.texel_format)
            TEX_PAL4:  return {28'h0, texel[3:0]};
            TEX_PAL8:  return {24'h0, texel[7:0]};
            TEX_PAL16: return {16'h0, texel[15:0]};
            default:   return texel;
        endcase
    endfunction

    function automatic int entry_index(input logic [31:0] raw, input logic [2:0] level);
        logic [31:0] idx;
        idx = (raw >> cfg.index_shift) & {24'h0, cfg.index_mask};
        idx = (idx | {23'h0, cfg.index_offset, 4'h0})
            & ((cfg.palette_format == PAL_8888) ? 32'h0FF : 32'h1FF);
        if (!cfg.shared_palette) begin
            idx = idx + {25'h0, level, 4'h0};
        end
        return int'(idx);
    endfunction

    function automatic logic [31:0] predict_color(input texel_word_t w);
        int          i;
        logic [31:0] entry;
        if (!w.src_ok) begin
            return 32'h0;
        end
        case (cfg.texel_format)
            TEX_565:  return unpack_color(PAL_565, {16'h0, w.texel[15:0]});
            TEX_5551: return unpack_color(PAL_5551, {16'h0, w.texel[15:0]});
            TEX_4444: return unpack_color(PAL_4444, {16'h0, w.texel[15:0]});
            TEX_8888: return w.texel;
            default: begin
                i = entry_index(texel_index_bits(w.texel), w.level);
                if (cfg.palette_format == PAL_8888) begin
                    entry = {pal_mem[(2*i+1) % PAL_WORDS], pal_mem[(2*i) % PAL_WORDS]};
                end else begin
                    entry = {16'h0, pal_mem[i % PAL_WORDS]};
                end
                return unpack_color(cfg.palette_format, entry);
            end
        endcase
    endfunction

    function automatic texel_word_t random_word();
        texel_word_t w;
        w.opcode = ($urandom_range(0, 99) < 15) ? OPCODE_WRITE : OPCODE_DECODE;
        case ($urandom_range(0, 3))
            0:       w.texel = $urandom_range(0, 255);
            1:       w.texel = $urandom_range(0, 65535);
            default: w.texel = $urandom;
        endcase
        w.level  = 3'($urandom_range(0, 7));
        w.src_ok = ($urandom_range(0, 9) != 0);
        w.addr   = 10'($urandom_range(0, PAL_WORDS - 1));
        w.data   = 16'($urandom_range(0, 65535));
        return w;
    endfunction

    // present one word, hold it until taken, then record what it should produce
    task automatic offer_word(input texel_word_t w, input bit typed, input logic [31:0] color);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= w.opcode;
        s_texel_value  <= w.texel;
        s_mip_level    <= w.level;
        s_source_valid <= w.src_ok;
        s_palette_addr <= w.addr;
        s_palette_data <= w.data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_in++;
        if (w.opcode == OPCODE_WRITE) begin
            if (w.addr < PAL_WORDS) begin
                pal_mem[w.addr] = w.data;
                pal_written[w.addr] = 1'b1;
            end
            pal_writes++;
        end else begin
            color_expect.push_back(typed ? color : predict_color(w));
        end
    endtask

    // load any palette halfword this decode would read that is not yet written, before it is sent
    task automatic prepare_palette(input texel_word_t w);
        int          i;
        int          lo;
        int          hi;
        texel_word_t fill;
        if (w.opcode == OPCODE_DECODE && w.src_ok && cfg.texel_format >= TEX_PAL4) begin
            i = entry_index(texel_index_bits(w.texel), w.level);
            lo = (cfg.palette_format == PAL_8888) ? 2*i : i;
            hi = (cfg.palette_format == PAL_8888) ? 2*i + 1 : i;
            for (int a = lo; a <= hi; a++) begin
                if (!pal_written[a % PAL_WORDS]) begin
                    fill = random_word();
                    fill.opcode = OPCODE_WRITE;
                    fill.addr = 10'(a % PAL_WORDS);
                    offer_word(fill, 1'b0, 32'h0);
                end
            end
        end
    endtask

    // drop valid, drain every pending color, then let trailing writes retire
    task automatic settle();
        s_valid <= 1'b0;
        while (color_expect.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TEXEL_FORMAT:   cfg.texel_format   = value[2:0];
            REG_PALETTE_FORMAT: cfg.palette_format = value[1:0];
            REG_INDEX_SHIFT:    cfg.index_shift    = value[4:0];
            REG_INDEX_MASK:     cfg.index_mask     = value[7:0];
            REG_INDEX_OFFSET:   cfg.index_offset   = value[4:0];
            REG_SHARED_PALETTE: cfg.shared_palette = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input cfg_t c);
        settle();
        apb_write(REG_TEXEL_FORMAT, {29'h0, c.texel_format});
        apb_write(REG_PALETTE_FORMAT, {30'h0, c.palette_format});
        apb_write(REG_INDEX_SHIFT, {27'h0, c.index_shift});
        apb_write(REG_INDEX_MASK, {24'h0, c.index_mask});
        apb_write(REG_INDEX_OFFSET, {27'h0, c.index_offset});
        apb_write(REG_SHARED_PALETTE, {31'h0, c.shared_palette});
    endtask

    function automatic cfg_t phase_config(input int phase);
        cfg_t c;
        c.texel_format   = 3'($urandom_range(0, 7));
        c.palette_format = 2'($urandom_range(0, 3));
        c.index_shift    = 5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : 0);
        c.index_mask     = 8'($urandom_range(0, 255));
        c.index_offset   = 5'($urandom_range(0, 31));
        c.shared_palette = 1'($urandom_range(0, 1));
        case (phase)
            0: c = '{TEX_565, PAL_565, 5'd0, 8'hFF, 5'd0, 1'b1};
            1: c = '{TEX_5551, PAL_5551, 5'd31, 8'h00, 5'd31, 1'b0};
            2: c = '{TEX_4444, PAL_4444, 5'd0, 8'hFF, 5'd0, 1'b1};
            3: c = '{TEX_8888, PAL_8888, 5'd0, 8'hFF, 5'd0, 1'b1};
            4: c = '{TEX_PAL4, PAL_565, 5'd0, 8'hFF, 5'd0, 1'b1};
            5: c = '{TEX_PAL8, PAL_8888, 5'd0, 8'hFF, 5'd31, 1'b0};
            6: c = '{TEX_PAL16, PAL_5551, 5'd31, 8'h00, 5'd31, 1'b0};
            7: c = '{TEX_PAL32, PAL_4444, 5'd31, 8'hFF, 5'd0, 1'b1};
            default: ;
        endcase
        return c;
    endfunction

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_ask) begin
            hold_taken <= hold_ask;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : color_check
        logic [31:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (color_expect.size() == 0) begin
                $error("color word with no decode pending: got %h", m_color);
                fail_count++;
            end else begin
                want = color_expect.pop_front();
                colors_seen++;
                if (m_color !== want) begin
                    $error("color mismatch: expected %h, actual %h", want, m_color);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #(5_000_000);
        $display("texel_format_clut_decoder_top verification failed");
        $finish;
    end

    initial begin
        texel_word_t w;
        cfg_t        c;
        dir_row_t    row;
        int          mode;

        cfg = '{TEX_565, PAL_565, 5'd0, 8'hFF, 5'd0, 1'b1};
        for (int a = 0; a < PAL_WORDS; a++) begin
            pal_mem[a] = '0;
            pal_written[a] = 1'b0;
        end

        //             tfmt       pfmt      op             texel         lvl   src   addr    data
        dir_rows[0]  = '{TEX_565,  PAL_565,  OPCODE_DECODE, 32'h00000000, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'hFF000000};
        dir_rows[1]  = '{TEX_565,  PAL_565,  OPCODE_DECODE, 32'h0000FFFF, 3'd7, 1'b1, 10'h3FF, 16'hFFFF,
                         1'b1, 32'hFFFFFFFF};
        // upper bits beyond the format are ignored
        dir_rows[2]  = '{TEX_565,  PAL_565,  OPCODE_DECODE, 32'hFFFF0000, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'hFF000000};
        // missing source forces black
        dir_rows[3]  = '{TEX_565,  PAL_565,  OPCODE_DECODE, 32'hFFFFFFFF, 3'd0, 1'b0, 10'h000, 16'h0000,
                         1'b1, 32'h00000000};
        dir_rows[4]  = '{TEX_5551, PAL_565,  OPCODE_DECODE, 32'h00008000, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'hFF000000};
        dir_rows[5]  = '{TEX_5551, PAL_565,  OPCODE_DECODE, 32'h00007FFF, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'h00FFFFFF};
        dir_rows[6]  = '{TEX_4444, PAL_565,  OPCODE_DECODE, 32'h0000F00F, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'hFF0000FF};
        dir_rows[7]  = '{TEX_4444, PAL_565,  OPCODE_DECODE, 32'h00000FF0, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'h00FFFF00};
        dir_rows[8]  = '{TEX_8888, PAL_565,  OPCODE_DECODE, 32'hFFFFFFFF, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'hFFFFFFFF};
        dir_rows[9]  = '{TEX_8888, PAL_565,  OPCODE_DECODE, 32'h00000000, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'h00000000};
        dir_rows[10] = '{TEX_8888, PAL_565,  OPCODE_WRITE,  32'hFFFFFFFF, 3'd7, 1'b1, 10'h000, 16'hFFFF,
                         1'b0, 32'h0};
        dir_rows[11] = '{TEX_8888, PAL_565,  OPCODE_WRITE,  32'h00000000, 3'd0, 1'b0, 10'h001, 16'h0000,
                         1'b0, 32'h0};
        dir_rows[12] = '{TEX_8888, PAL_565,  OPCODE_WRITE,  32'h00000000, 3'd0, 1'b1, 10'h3FF, 16'h1234,
                         1'b0, 32'h0};
        dir_rows[13] = '{TEX_PAL4, PAL_565,  OPCODE_DECODE, 32'hFFFFFFF0, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'hFFFFFFFF};
        dir_rows[14] = '{TEX_PAL8, PAL_565,  OPCODE_DECODE, 32'h00000101, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'hFF000000};
        dir_rows[15] = '{TEX_PAL16, PAL_5551, OPCODE_DECODE, 32'hFFFF0000, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'hFFFFFFFF};
        dir_rows[16] = '{TEX_PAL16, PAL_4444, OPCODE_DECODE, 32'h00000001, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'h00000000};
        dir_rows[17] = '{TEX_PAL32, PAL_8888, OPCODE_DECODE, 32'h00000000, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b1, 32'h0000FFFF};
        dir_rows[18] = '{TEX_PAL32, PAL_8888, OPCODE_DECODE, 32'h00000000, 3'd0, 1'b0, 10'h000, 16'h0000,
                         1'b1, 32'h00000000};
        dir_rows[19] = '{TEX_PAL4, PAL_4444, OPCODE_DECODE, 32'h000000E1, 3'd5, 1'b1, 10'h000, 16'h0000,
                         1'b0, 32'h0};
        dir_rows[20] = '{TEX_PAL4, PAL_4444, OPCODE_WRITE,  32'h00000000, 3'd0, 1'b1, 10'h002, 16'hABCD,
                         1'b0, 32'h0};
        dir_rows[21] = '{TEX_PAL8, PAL_565,  OPCODE_DECODE, 32'h00000002, 3'd0, 1'b1, 10'h000, 16'h0000,
                         1'b0, 32'h0};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = dir_rows[r];
            if (row.tfmt != cfg.texel_format || row.pfmt != cfg.palette_format) begin
                settle();
                apb_write(REG_TEXEL_FORMAT, {29'h0, row.tfmt});
                apb_write(REG_PALETTE_FORMAT, {30'h0, row.pfmt});
            end
            w.opcode = row.opcode;
            w.texel  = row.texel;
            w.level  = row.level;
            w.src_ok = row.src_ok;
            w.addr   = row.addr;
            w.data   = row.data;
            offer_word(w, row.typed, row.color);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            c = phase_config(phase);
            apply_config(c);
            mode = phase % 4;
            send_idle_pct  = (mode == 1) ? 87 : (mode == 3) ? 11 : 0;
            recv_stall_pct <= (mode == 2) ? 87 : (mode == 3) ? 11 : 0;
            // long receiver hold-off while words keep coming: back up the queue
            if (phase == 4 || phase == 8) begin
                hold_ask <= hold_ask + 1;
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                w = random_word();
                prepare_palette(w);
                offer_word(w, 1'b0, 32'h0);
            end
        end

        settle();
        $display("Run covered %0d input words (%0d palette writes) over %0d register settings,",
                 words_in, pal_writes, PHASES + 1);
        $display("all eight texel formats and four palette formats, %0d colors compared.",
                 colors_seen);
        if (fail_count == 0) begin
            $display("texel_format_clut_decoder_top verification clean");
        end else begin
            $display("texel_format_clut_decoder_top verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/tcd_pkg.sv
rtl/tcd_front.sv
rtl/tcd_queue.sv
rtl/tcd_back.sv
rtl/texel_format_clut_decoder_top.sv
bench/tb_texel_format_clut_decoder_top.sv
